>>> src/wlef_pkg.sv
// Shared types and constants for the windowed local extremum finder.
// No dependencies; imported by the top level.
package wlef_pkg;

    // Fixed field widths of the channels
    localparam int IDX_BITS       = 10;
    localparam int VALUE_BITS     = 16;
    localparam int SLEN_BITS      = 11;
    localparam int HWIN_BITS      = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGNAL_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_WINDOW   = 2'd1;

    // Register reset values
    localparam logic [SLEN_BITS-1:0] SLEN_RESET = 11'd1024;
    localparam logic [HWIN_BITS-1:0] HWIN_RESET = 5'd2;

    // Input item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Query sequencer
    typedef enum logic [3:0] {
        S_IDLE,   // waiting for an item
        S_CENT,   // read the centre sample
        S_CENTW,  // capture centre, update interval extreme, set up window
        S_WIN,    // stream window reads through the comparator
        S_PUSH,   // hand the held peak to the output register
        S_FIN,    // end of interval
        S_FBRD,   // read the fallback sample (empty interval)
        S_FBW,    // capture the fallback sample
        S_FBEM    // emit the fallback item
    } state_t;

endpackage

>>> src/wlef_sample_ram.sv
// Sample store: one write port, one read port with registered read data.
// No dependencies.
module wlef_sample_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/windowed_local_extremum_finder_top.sv
// Windowed local extremum finder, top level: sequencer, comparator, output register.
// Depends on wlef_pkg and wlef_sample_ram.
//
// Usage
//   s_ channel (valid/ready): kind 0 loads sample_value at sample_index; kind 1
//   runs a query over [left_index, right_index], clipped to MAX_SPAN indices.
//   m_ channel (valid/ready): one item per peak in ascending index order, last
//   set on the final one; with no peak, one fallback item (is_fallback, last).
//   cfg channel (valid/ready), always ready: index 0 signal_length, index 1
//   half_window; the user must write it only while idle, unchecked by the block.
// Load and query sequence
//   A load is written to the store on acceptance. A query scans each index with one
//   sample-memory read port and one comparator: a centre read (S_CENT, S_CENTW), up to
//   2*half_window window reads at one a cycle (stopping at the first sample beyond the
//   centre), S_PUSH to hand on a held peak and S_FIN to close the interval.
//   s_ready is low for the whole query.
// Reset and stall
//   aresetn clears the sequencer and the output valid flag and sets the registers to
//   their reset values; the sample store is not cleared. If the receiver
//   stalls, the scan holds at its next result until the output register frees.
module windowed_local_extremum_finder_top #(
    parameter int SAMPLE_DEPTH    = 1024,
    parameter int SAMPLE_BITS     = 16,
    parameter int MAX_SPAN        = 64,
    parameter int MAX_HALF_WINDOW = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input items
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_kind,
    input  logic [wlef_pkg::IDX_BITS-1:0]         s_sample_index,
    input  logic signed [wlef_pkg::VALUE_BITS-1:0] s_sample_value,
    input  logic [wlef_pkg::IDX_BITS-1:0]         s_left_index,
    input  logic [wlef_pkg::IDX_BITS-1:0]         s_right_index,
    input  logic                                  s_find_minimum,
    // result items
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [wlef_pkg::IDX_BITS-1:0]         m_peak_index,
    output logic signed [wlef_pkg::VALUE_BITS-1:0] m_peak_value,
    output logic                                  m_is_fallback,
    output logic                                  m_last,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wlef_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wlef_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    import wlef_pkg::*;

    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    // signed index width: room for i+hw, left+span and -hw
    localparam int IW_A   = $clog2(SAMPLE_DEPTH + MAX_HALF_WINDOW + MAX_SPAN) + 2;
    localparam int IW     = (IW_A > 13) ? IW_A : 13;

    typedef logic signed [IW-1:0] sidx_t;

    // ---------------- registers ----------------
    state_t                  state_reg, state_next;
    logic [SLEN_BITS-1:0]    slen_reg, slen_next;
    logic [HWIN_BITS-1:0]    hwin_reg, hwin_next;

    sidx_t                   i_reg, i_next;
    sidx_t                   right_reg, right_next;
    sidx_t                   hw_reg, hw_next;
    sidx_t                   sl_reg, sl_next;
    sidx_t                   j_reg, j_next;
    sidx_t                   hi_reg, hi_next;
    sidx_t                   best_reg, best_next;
    logic                    rv_reg, rv_next;
    logic                    first_reg, first_next;
    logic                    mn_reg, mn_next;
    logic [SAMPLE_BITS-1:0]  c_reg, c_next;
    logic [SAMPLE_BITS-1:0]  bestv_reg, bestv_next;
    logic [IDX_BITS-1:0]     pend_idx_reg, pend_idx_next;
    logic [SAMPLE_BITS-1:0]  pend_val_reg, pend_val_next;
    logic                    pend_valid_reg, pend_valid_next;

    logic                    m_valid_reg, m_valid_next;
    logic [IDX_BITS-1:0]     out_idx_reg, out_idx_next;
    logic [VALUE_BITS-1:0]   out_val_reg, out_val_next;
    logic                    out_fb_reg, out_fb_next;
    logic                    out_last_reg, out_last_next;

    // ---------------- memory ----------------
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [SAMPLE_BITS-1:0]  ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    sidx_t                   raddr_idx;

    wlef_sample_ram #(
        .DEPTH (SAMPLE_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // addresses wrap modulo the store depth
    logic [IW-1:0] sidx_ext, left_ext, right_ext;
    assign sidx_ext  = IW'(s_sample_index);
    assign left_ext  = IW'(s_left_index);
    assign right_ext = IW'(s_right_index);

    assign ram_waddr = sidx_ext[ADDR_W-1:0];
    assign ram_wdata = SAMPLE_BITS'($unsigned(s_sample_value));
    assign ram_raddr = raddr_idx[ADDR_W-1:0];

    // ---------------- shared comparator ----------------
    logic [SAMPLE_BITS-1:0] cmp_b;
    logic                   cmp_hit;

    assign cmp_b   = (state_reg == S_WIN) ? c_reg : bestv_reg;
    assign cmp_hit = mn_reg ? ($signed(ram_rdata) < $signed(cmp_b))
                            : ($signed(ram_rdata) > $signed(cmp_b));

    // ---------------- query setup ----------------
    sidx_t left_m, right_m, right_c, hw_sat, sl_sat, span_end;

    always_comb begin
        left_m   = $signed(IW'(left_ext[ADDR_W-1:0]));
        right_m  = $signed(IW'(right_ext[ADDR_W-1:0]));
        span_end = left_m + sidx_t'(MAX_SPAN - 1);
        right_c  = (right_m > span_end) ? span_end : right_m;
        hw_sat   = ($signed(IW'(hwin_reg)) > sidx_t'(MAX_HALF_WINDOW))
                   ? sidx_t'(MAX_HALF_WINDOW) : $signed(IW'(hwin_reg));
        sl_sat   = ($signed(IW'(slen_reg)) > sidx_t'(SAMPLE_DEPTH))
                   ? sidx_t'(SAMPLE_DEPTH) : $signed(IW'(slen_reg));
    end

    // window bounds of the current centre
    sidx_t lo_w, hi_w, lo_raw, hi_raw, sl_top;

    always_comb begin
        lo_raw = i_reg - hw_reg;
        hi_raw = i_reg + hw_reg;
        sl_top = sl_reg - sidx_t'(1);
        lo_w   = (lo_raw < sidx_t'(0)) ? sidx_t'(0) : lo_raw;
        hi_w   = (hi_raw > sl_top) ? sl_top : hi_raw;
    end

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        slen_next = slen_reg;
        hwin_next = hwin_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SIGNAL_LENGTH: slen_next = cfg_data;
                CFG_HALF_WINDOW:   hwin_next = cfg_data[HWIN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    logic  out_free, out_load;
    logic  decided, is_peak, advance;
    sidx_t j_inc;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign j_inc    = ((j_reg + sidx_t'(1)) == i_reg) ? j_reg + sidx_t'(2)
                                                    : j_reg + sidx_t'(1);

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        right_next      = right_reg;
        hw_next         = hw_reg;
        sl_next         = sl_reg;
        j_next          = j_reg;
        hi_next         = hi_reg;
        best_next       = best_reg;
        rv_next         = rv_reg;
        first_next      = first_reg;
        mn_next         = mn_reg;
        c_next          = c_reg;
        bestv_next      = bestv_reg;
        pend_idx_next   = pend_idx_reg;
        pend_val_next   = pend_val_reg;
        pend_valid_next = pend_valid_reg;
        out_idx_next    = out_idx_reg;
        out_val_next    = out_val_reg;
        out_fb_next     = out_fb_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        ram_we          = 1'b0;
        raddr_idx       = j_reg;
        decided         = 1'b0;
        is_peak         = 1'b0;
        advance         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_LOAD) begin
                        ram_we = 1'b1;
                    end else begin
                        mn_next         = s_find_minimum;
                        hw_next         = hw_sat;
                        sl_next         = sl_sat;
                        i_next          = left_m;
                        right_next      = right_c;
                        best_next       = left_m;
                        first_next      = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = (left_m > right_c) ? S_FBRD : S_CENT;
                    end
                end
            end

            S_CENT: begin
                raddr_idx  = i_reg;
                state_next = S_CENTW;
            end

            S_CENTW: begin
                // centre sample arrives; track the first extreme of the interval
                c_next = ram_rdata;
                if (first_reg || cmp_hit) begin
                    best_next  = i_reg;
                    bestv_next = ram_rdata;
                end
                first_next = 1'b0;
                j_next     = (lo_w == i_reg) ? lo_w + sidx_t'(1) : lo_w;
                hi_next    = hi_w;
                rv_next    = 1'b0;
                state_next = S_WIN;
            end

            S_WIN: begin
                if (rv_reg && cmp_hit) begin
                    // a neighbour lies beyond the centre
                    decided = 1'b1;
                    is_peak = 1'b0;
                end else if (!rv_reg && (j_reg > hi_reg)) begin
                    decided = 1'b1;
                    is_peak = 1'b1;
                end else begin
                    raddr_idx = j_reg;
                    rv_next   = (j_reg <= hi_reg);
                    if (j_reg <= hi_reg) begin
                        j_next = j_inc;
                    end
                end
                if (decided) begin
                    rv_next = 1'b0;
                    if (is_peak && pend_valid_reg) begin
                        state_next = S_PUSH;
                    end else begin
                        if (is_peak) begin
                            pend_idx_next   = i_reg[IDX_BITS-1:0];
                            pend_val_next   = c_reg;
                            pend_valid_next = 1'b1;
                        end
                        advance = 1'b1;
                    end
                end
            end

            S_PUSH: begin
                // held peak goes out, the new one takes its place
                if (out_free) begin
                    out_load      = 1'b1;
                    out_idx_next  = pend_idx_reg;
                    out_val_next  = VALUE_BITS'(pend_val_reg);
                    out_fb_next   = 1'b0;
                    out_last_next = 1'b0;
                    pend_idx_next = i_reg[IDX_BITS-1:0];
                    pend_val_next = c_reg;
                    advance       = 1'b1;
                end
            end

            S_FIN: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_idx_next    = pend_idx_reg;
                        out_val_next    = VALUE_BITS'(pend_val_reg);
                        out_fb_next     = 1'b0;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end else begin
                    state_next = S_FBEM;
                end
            end

            S_FBRD: begin
                raddr_idx  = best_reg;
                state_next = S_FBW;
            end

            S_FBW: begin
                bestv_next = ram_rdata;
                state_next = S_FBEM;
            end

            S_FBEM: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_idx_next  = best_reg[IDX_BITS-1:0];
                    out_val_next  = VALUE_BITS'(bestv_reg);
                    out_fb_next   = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next centre or close the interval
        if (advance) begin
            if (i_reg == right_reg) begin
                state_next = S_FIN;
            end else begin
                i_next     = i_reg + sidx_t'(1);
                state_next = S_CENT;
            end
        end
    end

    // output register
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slen_reg       <= SLEN_RESET;
            hwin_reg       <= HWIN_RESET;
            pend_valid_reg <= 1'b0;
            rv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slen_reg       <= slen_next;
            hwin_reg       <= hwin_next;
            pend_valid_reg <= pend_valid_next;
            rv_reg         <= rv_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        right_reg    <= right_next;
        hw_reg       <= hw_next;
        sl_reg       <= sl_next;
        j_reg        <= j_next;
        hi_reg       <= hi_next;
        best_reg     <= best_next;
        first_reg    <= first_next;
        mn_reg       <= mn_next;
        c_reg        <= c_next;
        bestv_reg    <= bestv_next;
        pend_idx_reg <= pend_idx_next;
        pend_val_reg <= pend_val_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_fb_reg   <= out_fb_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_peak_index  = out_idx_reg;
    assign m_peak_value  = $signed(out_val_reg);
    assign m_is_fallback = out_fb_reg;
    assign m_last        = out_last_reg;

    // ---------------- assertions ----------------
    // no peak is left held once the sequencer is back to idle
    a_pend_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held peak left over at end of query");

    // window reads stay inside the clamped signal
    a_win_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WIN && j_reg <= hi_reg) |-> (j_reg >= sidx_t'(0) && j_reg < sl_reg))
        else $error("window read outside signal bounds");

    // a non-final result always leaves another peak held
    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !out_last_next) |=> pend_valid_reg)
        else $error("non-final result without a following peak");

    // a fallback item always closes its query
    a_fb_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_fb_reg) |-> out_last_reg)
        else $error("fallback item not flagged last");

    // the scan pointer never passes the clipped interval end
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CENT || state_reg == S_CENTW || state_reg == S_WIN)
        |-> (i_reg <= right_reg))
        else $error("scan index beyond interval end");

endmodule

>>> sim/windowed_local_extremum_finder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for windowed_local_extremum_finder_top: loads and queries in,
// peak items out, checked against an in-bench predictor. Depends on wlef_pkg and the RTL.
module windowed_local_extremum_finder_top_tb;
    import wlef_pkg::*;

    localparam int SAMPLE_DEPTH    = 1024;
    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_SPAN        = 64;
    localparam int MAX_HALF_WINDOW = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd2;

    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 38;

    // One input item
    typedef struct {
        logic                         kind;
        logic [IDX_BITS-1:0]          sample_index;
        logic signed [VALUE_BITS-1:0] sample_value;
        logic [IDX_BITS-1:0]          left_index;
        logic [IDX_BITS-1:0]          right_index;
        logic                         find_minimum;
    } stim_t;

    // One result item
    typedef struct {
        logic [IDX_BITS-1:0]          peak_index;
        logic signed [VALUE_BITS-1:0] peak_value;
        logic                         is_fallback;
        logic                         last;
    } peak_t;

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_kind = KIND_LOAD;
    logic [IDX_BITS-1:0]          s_sample_index = '0;
    logic signed [VALUE_BITS-1:0] s_sample_value = '0;
    logic [IDX_BITS-1:0]          s_left_index = '0;
    logic [IDX_BITS-1:0]          s_right_index = '0;
    logic                         s_find_minimum = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [IDX_BITS-1:0]          m_peak_index;
    logic signed [VALUE_BITS-1:0] m_peak_value;
    logic                         m_is_fallback;
    logic                         m_last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = CFG_SIGNAL_LENGTH;
    logic [CFG_DATA_BITS-1:0]     cfg_data = '0;

    // Stimulus and expectations
    stim_t queued_items[$];
    stim_t in_flight;
    peak_t awaited_peaks[$];
    int    items_queued = 0;
    int    fail_count = 0;

    // Predictor state: sample store and register mirrors
    logic signed [VALUE_BITS-1:0] shadow_samples [SAMPLE_DEPTH];
    logic [SLEN_BITS-1:0]         mirror_slen = SLEN_RESET;
    logic [HWIN_BITS-1:0]         mirror_hwin = HWIN_RESET;
    bit                           loaded_mask [SAMPLE_DEPTH];

    // Idling and hold-off control
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    windowed_local_extremum_finder_top #(
        .SAMPLE_DEPTH   (SAMPLE_DEPTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_SPAN       (MAX_SPAN),
        .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_sample_index(s_sample_index),
        .s_sample_value(s_sample_value),
        .s_left_index  (s_left_index),
        .s_right_index (s_right_index),
        .s_find_minimum(s_find_minimum),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak_index  (m_peak_index),
        .m_peak_value  (m_peak_value),
        .m_is_fallback (m_is_fallback),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // a is strictly beyond b in the search direction
    function automatic bit outranks(logic signed [VALUE_BITS-1:0] a,
                                    logic signed [VALUE_BITS-1:0] b, bit want_min);
        return want_min ? (a < b) : (a > b);
    endfunction

    // Apply one accepted item: store a load, or work out the peak items of a query
    function automatic void predict_peaks(stim_t it);
        int    first, span_end, reach, bound, i, j, lo, hi, best;
        int    found[$];
        bit    standing;
        peak_t res;
        if (it.kind == KIND_LOAD) begin
            shadow_samples[it.sample_index] = it.sample_value;
            return;
        end
        first    = it.left_index;
        span_end = it.right_index;
        if (span_end > first + MAX_SPAN - 1) span_end = first + MAX_SPAN - 1;
        reach = (mirror_hwin > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : mirror_hwin;
        bound = (mirror_slen > SAMPLE_DEPTH) ? SAMPLE_DEPTH : mirror_slen;
        for (i = first; i <= span_end; i++) begin
            lo = (i - reach < 0) ? 0 : i - reach;
            hi = (i + reach > bound - 1) ? bound - 1 : i + reach;
            standing = 1'b1;
            for (j = lo; j <= hi; j++)
                if (j != i && outranks(shadow_samples[j], shadow_samples[i], it.find_minimum))
                    standing = 1'b0;
            if (standing) found.push_back(i);
        end
        // no peak: first extreme of the interval (left itself when the interval is empty)
        if (found.size() == 0) begin
            best = first;
            for (i = first + 1; i <= span_end; i++)
                if (outranks(shadow_samples[i], shadow_samples[best], it.find_minimum))
                    best = i;
            res.peak_index  = IDX_BITS'(best);
            res.peak_value  = shadow_samples[best];
            res.is_fallback = 1'b1;
            res.last        = 1'b1;
            awaited_peaks.push_back(res);
        end else begin
            foreach (found[k]) begin
                res.peak_index  = IDX_BITS'(found[k]);
                res.peak_value  = shadow_samples[found[k]];
                res.is_fallback = 1'b0;
                res.last        = (k == found.size() - 1);
                awaited_peaks.push_back(res);
            end
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    // Sample values: often a narrow band so that ties and plateaux are common
    function automatic logic signed [VALUE_BITS-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return VALUE_BITS'(int'($urandom_range(6)) - 3);
        if (pick < 60) return VALUE_BITS'($urandom);
        if (pick < 80) return VALUE_BITS'(int'($urandom_range(400)) - 200);
        case ($urandom_range(3))
            0: return VALUE_BITS'(-32768);
            1: return VALUE_BITS'(32767);
            2: return VALUE_BITS'(-1);
            default: return '0;
        endcase
    endfunction

    task automatic queue_load(int idx, logic signed [VALUE_BITS-1:0] value);
        stim_t it;
        it.kind         = KIND_LOAD;
        it.sample_index = IDX_BITS'(idx);
        it.sample_value = value;
        it.left_index   = IDX_BITS'($urandom);
        it.right_index  = IDX_BITS'($urandom);
        it.find_minimum = 1'($urandom);
        queued_items.push_back(it);
        loaded_mask[idx] = 1'b1;
        items_queued++;
    endtask

    // Queue a query, loading first every entry its scan and windows may touch
    task automatic queue_query(int left, int right, bit want_min);
        int    span_end, reach, lo, hi, k;
        stim_t it;
        span_end = (right > left + MAX_SPAN - 1) ? left + MAX_SPAN - 1 : right;
        reach = (mirror_hwin > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : mirror_hwin;
        lo = (left - reach < 0) ? 0 : left - reach;
        hi = ((span_end > left) ? span_end : left) + reach;
        if (hi > SAMPLE_DEPTH - 1) hi = SAMPLE_DEPTH - 1;
        for (k = lo; k <= hi; k++)
            if (!loaded_mask[k]) queue_load(k, random_sample());
        it.kind         = KIND_QUERY;
        it.sample_index = IDX_BITS'($urandom);
        it.sample_value = VALUE_BITS'($urandom);
        it.left_index   = IDX_BITS'(left);
        it.right_index  = IDX_BITS'(right);
        it.find_minimum = want_min;
        queued_items.push_back(it);
        items_queued++;
    endtask

    task automatic random_query(int hot);
        int left, right, pick;
        pick = $urandom_range(99);
        if (pick < 8) left = $urandom_range(SAMPLE_DEPTH - 1);
        else if (pick < 20)
            left = $urandom_range(1) ? $urandom_range(15) : SAMPLE_DEPTH - 1 - $urandom_range(15);
        else left = hot + $urandom_range(100);
        if (left > SAMPLE_DEPTH - 1) left = SAMPLE_DEPTH - 1;
        pick = $urandom_range(99);
        if (pick < 75) right = left + $urandom_range(15);
        else if (pick < 87) begin
            // empty interval
            if (left == 0) left = 1;
            right = left - 1 - $urandom_range(left - 1);
        end else if (pick < 95) right = left + MAX_SPAN + $urandom_range(150);
        else right = $urandom_range(SAMPLE_DEPTH - 1);
        if (right > SAMPLE_DEPTH - 1) right = SAMPLE_DEPTH - 1;
        queue_query(left, right, 1'($urandom));
    endtask

    // Register write; only called while the block is idle
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, int value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_SIGNAL_LENGTH) mirror_slen = SLEN_BITS'(value);
        else if (idx == CFG_HALF_WINDOW) mirror_hwin = HWIN_BITS'(value);
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: every item taken, every result back, then let trailing loads finish
    task automatic wait_settled();
        while (queued_items.size() != 0 || s_valid || awaited_peaks.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(int slen, int hwin, int snd_idle, int rcv_idle, bit pressure);
        int hot, goal;
        write_register(CFG_SIGNAL_LENGTH, slen);
        write_register(CFG_HALF_WINDOW, hwin);
        @(negedge aclk);
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        hot  = $urandom_range(SAMPLE_DEPTH - 128);
        goal = items_queued + PHASE_ITEMS;
        // long receiver hold-off behind a long query, sender keeps offering
        if (pressure) begin
            hold_token++;
            queue_query(hot, hot + MAX_SPAN + 20, 1'b0);
        end
        while (items_queued < goal) begin
            if ($urandom_range(99) < 35)
                queue_load($urandom_range(3) == 0 ? $urandom_range(SAMPLE_DEPTH - 1)
                                                  : hot + $urandom_range(127),
                           random_sample());
            else random_query(hot);
        end
        wait_settled();
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_peaks(in_flight);
            if (!s_valid || s_ready) begin
                if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = queued_items.pop_front();
                    s_kind         <= in_flight.kind;
                    s_sample_index <= in_flight.sample_index;
                    s_sample_value <= in_flight.sample_value;
                    s_left_index   <= in_flight.left_index;
                    s_right_index  <= in_flight.right_index;
                    s_find_minimum <= in_flight.find_minimum;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result ready, with random stalls and the occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin : result_check
        peak_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_peaks.size() == 0) begin
                report_mismatch($sformatf("unexpected item: idx %0d val %0d fb %0b last %0b",
                                          m_peak_index, m_peak_value, m_is_fallback, m_last));
            end else begin
                want = awaited_peaks.pop_front();
                if (m_peak_index !== want.peak_index || m_peak_value !== want.peak_value ||
                    m_is_fallback !== want.is_fallback || m_last !== want.last)
                    report_mismatch($sformatf(
                        "got idx %0d val %0d fb %0b last %0b, want idx %0d val %0d fb %0b last %0b",
                        m_peak_index, m_peak_value, m_is_fallback, m_last,
                        want.peak_index, want.peak_value, want.is_fallback, want.last));
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("windowed_local_extremum_finder_top_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Sequence of phases
    initial begin
        int ramp [8];
        int top  [5];
        ramp = '{32767, -32768, 7, 7, -32768, 0, 32767, -1};
        top  = '{-32768, 100, 100, -5, 32767};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 30;
        recv_idle_pct = 67;

        // Directed: extremes at both ends of the store, reset registers
        foreach (ramp[k]) queue_load(k, VALUE_BITS'(ramp[k]));
        foreach (top[k]) queue_load(SAMPLE_DEPTH - 5 + k, VALUE_BITS'(top[k]));
        queue_query(0, 5, 1'b0);
        queue_query(0, 5, 1'b1);
        queue_query(1, 2, 1'b0);                       // no peak, fallback extreme
        queue_query(4, 1, 1'b0);                       // empty interval
        queue_query(SAMPLE_DEPTH - 3, SAMPLE_DEPTH - 1, 1'b0);
        queue_query(SAMPLE_DEPTH - 5, SAMPLE_DEPTH - 1, 1'b1);
        wait_settled();

        // Random phases over register settings, extremes and saturation included
        run_phase(2047, 31, 30, 67, 1'b0);
        run_phase(1, 0, 30, 67, 1'b1);
        run_phase(0, 16, 67, 30, 1'b0);
        write_register(CFG_UNUSED, 1);
        run_phase($urandom_range(2, 1023), $urandom_range(1, 15), 67, 30, 1'b0);
        run_phase(1024, 5, 0, 0, 1'b0);
        run_phase($urandom_range(2047), $urandom_range(31), 0, 0, 1'b0);

        if (fail_count == 0)
            $display("windowed_local_extremum_finder_top_tb passed");
        else
            $display("windowed_local_extremum_finder_top_tb failed");
        $finish;
    end

endmodule
